@@ sv/hrls_pkg.sv @@
// Shared types and constants for the HTTP response length scanner.
package hrls_pkg;

  localparam int unsigned NAME_LEN = 14;
  localparam int unsigned SKIP_LEN = 2;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // "Content-Length", first character at index 0
  localparam logic [7:0] FIELD_NAME [NAME_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
    8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
  };

  typedef enum logic [1:0] {
    PH_NAME,
    PH_SKIP,
    PH_DIGITS,
    PH_TERM
  } phase_t;

  // one classified byte as it sits in the queue
  typedef struct packed {
    logic                last;
    logic                cr;
    logic                lf;
    logic                digit;
    logic [3:0]          digit_val;
    logic [NAME_LEN-1:0] name_hit;
  } class_t;

endpackage

@@ sv/http_response_length_scanner.sv @@
// Top level of the HTTP response length scanner.
// Usage:
// - Slave stream: one response byte per word in s_tdata[7:0]; s_tlast marks the
//   last byte of a message. A word is taken when s_tvalid and s_tready are high.
// - Master stream: one word per message, m_tdata = total length (content length
//   plus header length, saturating), m_tuser[0] = Content-Length seen,
//   m_tuser[1] = header terminator seen.
// - Throughput: one byte per clock, sustained, across message boundaries, while the output is not stalled.
// - Result path: after the edge that takes the last byte, m_tvalid rises once it has
//   passed the queue write, the scanner step and two result stages.
// - Stall: while m_tvalid is high and m_tready low the output word holds and the
//   scanner stops; the byte queue (2**QUEUE_ADDR_BITS words) keeps filling and
//   s_tready falls only when it is full.
// - Reset (rst, synchronous): empties the queue, drops results in flight and
//   returns the scanner to the name search at byte 0. The scanner also clears
//   itself after each last byte.
module http_response_length_scanner #(
  parameter int unsigned LENGTH_BITS     = 32,
  parameter int unsigned QUEUE_ADDR_BITS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] total_length
  output logic [1:0]  m_tuser    // [0] length_field_seen, [1] header_end_seen
);

  localparam int unsigned QW = $bits(hrls_pkg::class_t);

  logic             full;
  logic             push;
  hrls_pkg::class_t push_data;
  logic             q_valid;
  logic [QW-1:0]    q_raw;
  logic             q_pop;
  logic             seen_len;
  logic             seen_end;

  // classify bytes on the way in
  hrls_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the input from scanner and output stalls
  hrls_queue #(
    .WIDTH     (QW),
    .ADDR_BITS (QUEUE_ADDR_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (q_valid),
    .out_data  (q_raw),
    .pop       (q_pop)
  );

  hrls_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (hrls_pkg::class_t'(q_raw)),
    .q_pop             (q_pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .total_length      (m_tdata),
    .length_field_seen (seen_len),
    .header_end_seen   (seen_end)
  );

  assign m_tuser = {seen_end, seen_len};

endmodule

@@ sv/hrls_front.sv @@
// Input side: accepts bytes and classifies them for the scanner.
module hrls_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,   // final_byte
  input  logic              full,
  output logic              push,
  output hrls_pkg::class_t  push_data
);

  logic [hrls_pkg::NAME_LEN-1:0] hit;

  for (genvar k = 0; k < hrls_pkg::NAME_LEN; k++) begin : g_hit
    assign hit[k] = (s_tdata == hrls_pkg::FIELD_NAME[k]);
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    push_data           = '0;
    push_data.last      = s_tlast;
    push_data.cr        = (s_tdata == hrls_pkg::CH_CR);
    push_data.lf        = (s_tdata == hrls_pkg::CH_LF);
    push_data.digit     = (s_tdata >= hrls_pkg::CH_ZERO) && (s_tdata <= hrls_pkg::CH_NINE);
    // ASCII digits carry their value in the low nibble
    push_data.digit_val = s_tdata[3:0];
    push_data.name_hit  = hit;
  end

endmodule

@@ sv/hrls_queue.sv @@
// Small register FIFO between the classifier and the scanner.
module hrls_queue #(
  parameter int unsigned WIDTH     = 22,
  parameter int unsigned ADDR_BITS = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  input  logic             pop
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0]     mem [DEPTH];
  logic [ADDR_BITS-1:0] wr_ptr;
  logic [ADDR_BITS-1:0] rd_ptr;
  logic [ADDR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == (ADDR_BITS+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/hrls_back.sv @@
// Scanner: field name, length digits and header terminator, plus result pipeline.
module hrls_back #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hrls_pkg::class_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      total_length,
  output logic             length_field_seen,
  output logic             header_end_seen
);

  localparam int unsigned L = LENGTH_BITS;
  localparam logic [L-1:0] LMAX = '1;

  typedef struct packed {
    logic         found;
    logic [2:0]   cnt;
    logic [L-1:0] pend;
    logic [L-1:0] start;
  } term_t;

  // one byte of the CR LF CR LF search; a full match waits for a byte that is not CR
  function automatic term_t term_feed(term_t t, logic cr, logic lf, logic [L-1:0] pos);
    term_t r;
    r = t;
    if (!t.found) begin
      if (t.cnt == 3'd4) begin
        if (!cr) begin
          r.found = 1'b1;
          r.start = t.pend;
          r.cnt   = 3'd0;
        end else begin
          r.cnt = 3'd3;
        end
      end else begin
        case (t.cnt)
          3'd0:    r.cnt = cr ? 3'd1 : 3'd0;
          3'd1:    r.cnt = lf ? 3'd2 : (cr ? 3'd1 : 3'd0);
          3'd2:    r.cnt = cr ? 3'd3 : 3'd0;
          default: r.cnt = lf ? 3'd4 : (cr ? 3'd1 : 3'd0);
        endcase
        if (r.cnt == 3'd4) begin
          r.pend = pos - L'(3);
        end
      end
    end
    return r;
  endfunction

  hrls_pkg::phase_t phase, phase_next;
  logic [3:0]       name_cnt, name_cnt_next;
  logic [1:0]       skip_cnt, skip_cnt_next;
  logic [L-1:0]     cv, cv_next;
  logic [L-1:0]     pos, pos_next;
  term_t            term, term_next;
  term_t            term_fed;
  logic [L+3:0]     digit_full;
  logic             fin_found;
  logic [L-1:0]     fin_start;

  // result pipeline
  logic             stall;
  logic             s1_valid, s2_valid;
  logic [L-1:0]     s1_cv, s1_start, s2_cv;
  logic             s1_found, s1_seen, s2_found, s2_seen;
  logic [L:0]       s2_off;
  logic [L+1:0]     sum;
  logic [L-1:0]     sat;
  logic [L+31:0]    sat_ext;

  assign stall = out_valid && !out_ready;
  assign q_pop = q_valid && !stall;

  always_comb begin
    phase_next    = phase;
    name_cnt_next = name_cnt;
    skip_cnt_next = skip_cnt;
    cv_next       = cv;
    term_next     = term;
    term_fed      = term_feed(term, q_data.cr, q_data.lf, pos);
    digit_full    = ({4'b0, cv} << 3) + ({4'b0, cv} << 1) + (L+4)'(q_data.digit_val);
    unique case (phase)
      hrls_pkg::PH_NAME: begin
        term_next = term_fed;
        if (q_data.name_hit[name_cnt]) begin
          name_cnt_next = name_cnt + 4'd1;
        end else begin
          name_cnt_next = {3'b0, q_data.name_hit[0]};
        end
        if (name_cnt_next == 4'(hrls_pkg::NAME_LEN)) begin
          phase_next    = hrls_pkg::PH_SKIP;
          skip_cnt_next = '0;
          cv_next       = '0;
          term_next     = '0;
        end
      end
      hrls_pkg::PH_SKIP: begin
        skip_cnt_next = skip_cnt + 2'd1;
        if (skip_cnt_next >= 2'(hrls_pkg::SKIP_LEN)) begin
          phase_next = hrls_pkg::PH_DIGITS;
        end
      end
      hrls_pkg::PH_DIGITS: begin
        if (q_data.digit) begin
          cv_next = (digit_full[L+3:L] != '0) ? LMAX : digit_full[L-1:0];
        end else begin
          phase_next = hrls_pkg::PH_TERM;
          term_next  = term_feed('0, q_data.cr, q_data.lf, pos);
        end
      end
      hrls_pkg::PH_TERM: begin
        term_next = term_fed;
      end
      default: begin
        phase_next = hrls_pkg::PH_NAME;
      end
    endcase
    pos_next  = (pos == LMAX) ? pos : pos + L'(1);
    // a full match still pending at the last byte qualifies
    fin_found = term_next.found || (term_next.cnt == 3'd4);
    fin_start = term_next.found ? term_next.start : term_next.pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= hrls_pkg::PH_NAME;
      name_cnt <= '0;
      skip_cnt <= '0;
      cv       <= '0;
      pos      <= '0;
      term     <= '0;
    end else if (q_pop) begin
      if (q_data.last) begin
        phase    <= hrls_pkg::PH_NAME;
        name_cnt <= '0;
        skip_cnt <= '0;
        cv       <= '0;
        pos      <= '0;
        term     <= '0;
      end else begin
        phase    <= phase_next;
        name_cnt <= name_cnt_next;
        skip_cnt <= skip_cnt_next;
        cv       <= cv_next;
        pos      <= pos_next;
        term     <= term_next;
      end
    end
  end

  // stage 1: capture the message totals at the last byte
  // stage 2: offset = terminator start + 4, or position + 2
  // stage 3: add content length and saturate into the output register
  assign sum     = {1'b0, s2_off} + {2'b0, s2_cv};
  assign sat     = (sum[L+1:L] != '0) ? LMAX : sum[L-1:0];
  assign sat_ext = {32'b0, sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid  <= q_pop && q_data.last;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_cv             <= cv_next;
      s1_found          <= fin_found;
      s1_start          <= fin_found ? fin_start : pos;
      s1_seen           <= (phase_next != hrls_pkg::PH_NAME);
      s2_cv             <= s1_cv;
      s2_off            <= {1'b0, s1_start} + (s1_found ? (L+1)'(4) : (L+1)'(2));
      s2_found          <= s1_found;
      s2_seen           <= s1_seen;
      total_length      <= sat_ext[31:0];
      length_field_seen <= s2_seen;
      header_end_seen   <= s2_found;
    end
  end

endmodule

@@ sv/hrls_checker.sv @@
// Port-level checks for the HTTP response length scanner, bound to the top level.
module hrls_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // messages whose last byte went in but whose result has not come out
  logic [7:0] open_msgs;
  logic       in_last;
  logic       out_take;

  assign in_last  = s_tvalid && s_tready && s_tlast;
  assign out_take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_msgs <= '0;
    end else if (in_last && !out_take) begin
      open_msgs <= open_msgs + 8'd1;
    end else if (out_take && !in_last) begin
      open_msgs <= open_msgs - 8'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_result_has_message: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> open_msgs != 8'd0)
    else $error("result word without a finished message");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_last && open_msgs == 8'd0 && !m_tvalid |=> !m_tvalid)
    else $error("result word appeared too soon after last byte");

endmodule

bind http_response_length_scanner hrls_checker u_hrls_checker (.*);
